/* design/assert_macros.svh */
// Assertion helpers; clk and arst_n are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/gwsd_pkg.sv */
package gwsd_pkg;

	// fixed field widths
	localparam int RATE_W   = 16;
	localparam int THR_W    = 16;
	localparam int SPREAD_W = 43;
	localparam int AXES     = 3;

	localparam logic [THR_W-1:0]    THR_RESET  = 16'd64;
	localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;

	// per-stage enables from the pipeline control to each axis lane
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic acc_upd;
		logic en_s4;
		logic en_s5;
	} gwsd_lane_ctl_t;

endpackage

/* design/gwsd_in_if.sv */
interface gwsd_in_if import gwsd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] rate_x;
	logic signed [RATE_W-1:0] rate_y;
	logic signed [RATE_W-1:0] rate_z;
	logic                     sample_valid;

	modport source (output valid, rate_x, rate_y, rate_z, sample_valid, input ready);
	modport sink   (input valid, rate_x, rate_y, rate_z, sample_valid, output ready);
endinterface

/* design/gwsd_out_if.sv */
interface gwsd_out_if import gwsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                stationary;
	logic                window_full;
	logic [SPREAD_W-1:0] max_spread;

	modport source (output valid, stationary, window_full, max_spread, input ready);
	modport sink   (input valid, stationary, window_full, max_spread, output ready);
endinterface

/* design/gwsd_wram.sv */
module gwsd_wram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, every cycle
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/gwsd_lane.sv */
module gwsd_lane import gwsd_pkg::*; #(
	parameter int WINDOW = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gwsd_lane_ctl_t                       ctl,
	input  logic signed [RATE_W-1:0]             rate,
	input  logic signed [RATE_W-1:0]             old,
	input  logic [32+2*$clog2(WINDOW)-1:0]       limit,
	output logic [31+2*$clog2(WINDOW)-1:0]       spread,
	output logic                                 below
);

	localparam int L   = $clog2(WINDOW);
	localparam int SW  = RATE_W + L;
	localparam int SQW = 31 + L;
	localparam int PW  = 31 + 2*L;
	localparam int LW  = 32 + 2*L;
	localparam logic [PW-1:0] WIN_C = PW'(WINDOW);

	logic signed [RATE_W-1:0]   new_s1, old_s1;
	logic signed [RATE_W-1:0]   new_s2, old_s2;
	logic signed [2*RATE_W-1:0] sqn, sqo;
	logic [2*RATE_W-2:0]        sqn_s2, sqo_s2;
	logic signed [SW-1:0]       sum_q;
	logic [SQW-1:0]             sumsq_q;
	logic [SW-1:0]              mag;
	logic [2*SW-1:0]            msq;
	logic [PW-1:0]              wsq;
	logic [PW-1:0]              wsq_s4, ssq_s4;
	logic [PW-1:0]              diff;
	logic [PW-1:0]              spread_s5;
	logic                       below_s5;

	// s1: incoming sample and the one it replaces (zero while filling)
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			new_s1 <= rate;
			old_s1 <= old;
		end
	end

	// s2: squares
	assign sqn = new_s1 * new_s1;
	assign sqo = old_s1 * old_s1;

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			new_s2 <= new_s1;
			old_s2 <= old_s1;
			sqn_s2 <= sqn[2*RATE_W-2:0];
			sqo_s2 <= sqo[2*RATE_W-2:0];
		end
	end

	// running sum and sum of squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (ctl.acc_upd) begin
			sum_q   <= sum_q + SW'(new_s2) - SW'(old_s2);
			sumsq_q <= sumsq_q + SQW'(sqn_s2) - SQW'(sqo_s2);
		end
	end

	// s4: WINDOW*sumsq and sum^2
	assign mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign msq = mag * mag;
	assign wsq = PW'(sumsq_q) * WIN_C;

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			wsq_s4 <= wsq;
			ssq_s4 <= msq[PW-1:0];
		end
	end

	// s5: spread and threshold compare
	assign diff = wsq_s4 - ssq_s4;

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			spread_s5 <= diff;
			below_s5  <= (LW'(diff) < limit);
		end
	end

	assign spread = spread_s5;
	assign below  = below_s5;

endmodule

/* design/gwsd_merge.sv */
module gwsd_merge import gwsd_pkg::*; #(
	parameter int PW = 43
) (
	input  logic                clk,
	input  logic                ld,
	input  logic                full,
	input  logic [PW-1:0]       spread [AXES],
	input  logic [AXES-1:0]     below,
	output logic                stationary,
	output logic                window_full,
	output logic [SPREAD_W-1:0] max_spread
);

	localparam int MW = (PW > SPREAD_W) ? PW : SPREAD_W;

	logic [PW-1:0]       m01, mall;
	logic [MW-1:0]       mx;
	logic                sat;
	logic [SPREAD_W-1:0] clipped;
	logic                stationary_q, window_full_q;
	logic [SPREAD_W-1:0] max_spread_q;

	// largest of the three lanes, clipped to the field
	assign m01     = (spread[0] > spread[1]) ? spread[0] : spread[1];
	assign mall    = (m01 > spread[2]) ? m01 : spread[2];
	assign mx      = MW'(mall);
	assign sat     = (mx > MW'(SPREAD_MAX));
	assign clipped = sat ? SPREAD_MAX : mx[SPREAD_W-1:0];

	// output register
	always_ff @(posedge clk) begin
		if (ld) begin
			stationary_q  <= full & (&below);
			window_full_q <= full;
			max_spread_q  <= full ? clipped : '0;
		end
	end

	assign stationary  = stationary_q;
	assign window_full = window_full_q;
	assign max_spread  = max_spread_q;

endmodule

/* design/gyro_window_stationary_detect.sv */
// channel   | dir | beat contents
// samples   | in  | rate_x, rate_y, rate_z (s16), sample_valid
// results   | out | stationary, window_full, max_spread (u43)
// cfg       | in  | cfg_we / cfg_wdata: std_threshold (u16)
//
// One sample beat per cycle unless results.ready stalls; result beats are registered.
// The per-axis accumulator update is a feedback loop, as are the slot and fill counters;
// the replaced sample is prefetched from the window RAM ahead of its use.
// Reset clears counters and sums and loads a threshold of 64; no RAM clear,
// entries are read only after the fill count says they were written.
// Stalls are elastic: every stage fills bubbles, results wait in the output register.
`include "assert_macros.svh"

module gyro_window_stationary_detect import gwsd_pkg::*; #(
	parameter int WINDOW = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	gwsd_in_if.sink           samples,
	gwsd_out_if.source        results,
	input  logic              cfg_we,
	input  logic [THR_W-1:0]  cfg_wdata
);

	localparam int L    = $clog2(WINDOW);
	localparam int AW   = L;
	localparam int FCW  = $clog2(WINDOW + 1);
	localparam int PW   = 31 + 2*L;
	localparam int LW   = 32 + 2*L;
	localparam int LIMW = THR_W + L;
	localparam logic [AW-1:0]  SLOT_LAST = AW'(WINDOW - 1);
	localparam logic [FCW-1:0] FILL_MAX  = FCW'(WINDOW);
	localparam logic [FCW-1:0] FILL_LAST = FCW'(WINDOW - 1);

	logic [THR_W-1:0]  thr_q;
	logic [LIMW-1:0]   limw_q;
	logic [LW-1:0]     limit_q;
	logic [AW-1:0]     slot_q, slot_nxt;
	logic [FCW-1:0]    fill_q;
	logic              accept, smp_ok, full_now, full_after;
	logic [3*RATE_W-1:0] rd_data;
	logic              v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
	logic              en1, en2, en3, en4, en5, en_o;
	logic              smp_s1, smp_s2;
	logic              full_s1, full_s2, full_s3, full_s4, full_s5;
	gwsd_lane_ctl_t    ctl;
	logic signed [RATE_W-1:0] rate_a [AXES];
	logic signed [RATE_W-1:0] old_a  [AXES];
	logic [PW-1:0]     spread_a [AXES];
	logic [AXES-1:0]   below_a;

	// threshold register and squared limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		limw_q  <= LIMW'(thr_q) * LIMW'(WINDOW);
		limit_q <= LW'(limw_q) * LW'(limw_q);
	end

	// elastic stage enables, output back to input
	assign en_o = !vo_q || results.ready;
	assign en5  = !v5_q || en_o;
	assign en4  = !v4_q || en5;
	assign en3  = !v3_q || en4;
	assign en2  = !v2_q || en3;
	assign en1  = !v1_q || en2;

	assign samples.ready = en1;
	assign accept        = samples.valid && en1;
	assign smp_ok        = accept && samples.sample_valid;

	// window bookkeeping
	assign full_now   = (fill_q == FILL_MAX);
	assign full_after = full_now || (samples.sample_valid && (fill_q == FILL_LAST));
	assign slot_nxt   = smp_ok ? ((slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1) : slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else begin
			slot_q <= slot_nxt;
			if (smp_ok && !full_now) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// sample ring; read port prefetches the slot the next sample replaces
	gwsd_wram #(
		.DEPTH (WINDOW),
		.WIDTH (3*RATE_W)
	) u_wram (
		.clk   (clk),
		.we    (smp_ok),
		.waddr (slot_q),
		.wdata ({samples.rate_x, samples.rate_y, samples.rate_z}),
		.raddr (slot_nxt),
		.rdata (rd_data)
	);

	// stage valids and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1)  v1_q <= samples.valid;
			if (en2)  v2_q <= v1_q;
			if (en3)  v3_q <= v2_q;
			if (en4)  v4_q <= v3_q;
			if (en5)  v5_q <= v4_q;
			if (en_o) vo_q <= v5_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			smp_s1  <= samples.sample_valid;
			full_s1 <= full_after;
		end
		if (en2) begin
			smp_s2  <= smp_s1;
			full_s2 <= full_s1;
		end
		if (en3) full_s3 <= full_s2;
		if (en4) full_s4 <= full_s3;
		if (en5) full_s5 <= full_s4;
	end

	// lane control
	always_comb begin
		ctl.en_s1   = en1;
		ctl.en_s2   = en2;
		ctl.acc_upd = en3 && v2_q && smp_s2;
		ctl.en_s4   = en4;
		ctl.en_s5   = en5;
	end

	// replaced sample counts only once the window is full
	assign rate_a[0] = samples.rate_x;
	assign rate_a[1] = samples.rate_y;
	assign rate_a[2] = samples.rate_z;
	assign old_a[0]  = full_now ? rd_data[3*RATE_W-1:2*RATE_W] : '0;
	assign old_a[1]  = full_now ? rd_data[2*RATE_W-1:RATE_W]   : '0;
	assign old_a[2]  = full_now ? rd_data[RATE_W-1:0]          : '0;

	// one lane per axis
	for (genvar a = 0; a < AXES; a++) begin : g_lane
		gwsd_lane #(
			.WINDOW (WINDOW)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.rate   (rate_a[a]),
			.old    (old_a[a]),
			.limit  (limit_q),
			.spread (spread_a[a]),
			.below  (below_a[a])
		);
	end

	// merge lanes into the result beat
	gwsd_merge #(
		.PW (PW)
	) u_merge (
		.clk         (clk),
		.ld          (en_o),
		.full        (full_s5),
		.spread      (spread_a),
		.below       (below_a),
		.stationary  (results.stationary),
		.window_full (results.window_full),
		.max_spread  (results.max_spread)
	);

	assign results.valid = vo_q;

	// checks
	`ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_MAX, "fill count beyond window")
	`ASSERT_NEXT(a_fill_inc, smp_ok && !full_now, fill_q == $past(fill_q) + 1'b1, "fill count missed a sample")
	`ASSERT_NEXT(a_slot_adv, smp_ok, slot_q == (($past(slot_q) == SLOT_LAST) ? '0 : $past(slot_q) + 1'b1), "write slot did not advance")
	`ASSERT_IMPLIES(a_still_full, results.valid && results.stationary, results.window_full, "stationary before window full")
	`ASSERT_IMPLIES(a_spread_zero, results.valid && !results.window_full, results.max_spread == '0, "spread reported while filling")

endmodule

/* dv/gwsd_checker.sv */
// Watches the sample and result channels, keeps its own copy of the window
// state and compares every result beat with the oldest predicted verdict.
module gwsd_checker import gwsd_pkg::*; #(
	parameter int WINDOW = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	gwsd_in_if               samples,
	gwsd_out_if              results,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic                stationary;
		logic                window_full;
		logic [SPREAD_W-1:0] max_spread;
	} verdict_t;

	// shadow window state
	logic signed [RATE_W-1:0] ring [WINDOW][AXES];
	int unsigned              slot;
	int unsigned              fill;
	longint                   axis_sum   [AXES];
	longint                   axis_sqsum [AXES];
	logic [THR_W-1:0]         threshold;

	verdict_t verdicts [$];
	verdict_t head;
	int       mismatches = 0;
	int       queued     = 0;

	assign errors  = mismatches;
	assign pending = queued;

	// replace the oldest sample (once full) and update sums and squares
	task automatic absorb_sample(input logic signed [RATE_W-1:0] x,
			input logic signed [RATE_W-1:0] y, input logic signed [RATE_W-1:0] z);
		logic signed [RATE_W-1:0] vals [AXES];
		longint                   prev;
		longint                   cur;
		vals[0] = x;
		vals[1] = y;
		vals[2] = z;
		for (int a = 0; a < AXES; a++) begin
			cur = vals[a];
			if (fill >= WINDOW) begin
				prev = ring[slot][a];
				axis_sum[a]   -= prev;
				axis_sqsum[a] -= prev * prev;
			end
			ring[slot][a]  = vals[a];
			axis_sum[a]   += cur;
			axis_sqsum[a] += cur * cur;
		end
		slot = (slot + 1) % WINDOW;
		if (fill < WINDOW)
			fill++;
	endtask

	// scaled variance per axis against (threshold*WINDOW)^2
	function automatic verdict_t judge_window();
		longint   lim;
		longint   spread;
		longint   worst;
		logic     full;
		logic     still;
		verdict_t v;
		full  = (fill >= WINDOW);
		still = full;
		worst = 0;
		lim   = longint'(threshold) * WINDOW;
		lim   = lim * lim;
		if (full) begin
			for (int a = 0; a < AXES; a++) begin
				spread = WINDOW * axis_sqsum[a] - axis_sum[a] * axis_sum[a];
				if (spread > worst)
					worst = spread;
				if (!(spread < lim))
					still = 1'b0;
			end
		end
		v.stationary  = still;
		v.window_full = full;
		v.max_spread  = (worst > longint'(SPREAD_MAX)) ? SPREAD_MAX : worst[SPREAD_W-1:0];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot      = 0;
			fill      = 0;
			threshold = THR_RESET;
			for (int a = 0; a < AXES; a++) begin
				axis_sum[a]   = 0;
				axis_sqsum[a] = 0;
			end
			verdicts.delete();
			queued = 0;
		end else begin
			// result beat against the oldest prediction
			if (results.valid && results.ready) begin
				if (verdicts.size() == 0) begin
					$error("result beat with no prediction waiting");
					mismatches++;
				end else begin
					head = verdicts[0];
					verdicts.delete(0);
					if (results.stationary !== head.stationary) begin
						$error("stationary: expected %0b, got %0b",
							head.stationary, results.stationary);
						mismatches++;
					end
					if (results.window_full !== head.window_full) begin
						$error("window_full: expected %0b, got %0b",
							head.window_full, results.window_full);
						mismatches++;
					end
					if (results.max_spread !== head.max_spread) begin
						$error("max_spread: expected %0d, got %0d",
							head.max_spread, results.max_spread);
						mismatches++;
					end
				end
			end
			// sample beat: invalid samples leave the window alone
			if (samples.valid && samples.ready) begin
				if (samples.sample_valid)
					absorb_sample(samples.rate_x, samples.rate_y, samples.rate_z);
				verdicts.insert(verdicts.size(), judge_window());
			end
			// the user must change the threshold only while the block is idle; this checker does not enforce it
			if (cfg_we)
				threshold = cfg_wdata;
			queued = verdicts.size();
		end
	end

endmodule

/* dv/tb_gyro_window_stationary_detect.sv */
module tb_gyro_window_stationary_detect;
	import gwsd_pkg::*;

	localparam int WINDOW      = 64;
	localparam int CLK_PERIOD  = 10;
	localparam int SETTLE      = 12;   // well past the pipeline depth
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 100;
	localparam int HOLD_CYCLES = 250;

	typedef enum int {M_QUIET, M_WILD, M_STEADY, M_SWING, M_RAILS} stim_mode_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [THR_W-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	int sent      = 0;
	int beats     = 0;

	gwsd_in_if  samples_if ();
	gwsd_out_if results_if ();

	gyro_window_stationary_detect #(.WINDOW(WINDOW)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	gwsd_checker #(.WINDOW(WINDOW)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// watchdog
	initial begin
		#(CLK_PERIOD * 400000);
		$display("FAIL gyro_window_stationary_detect");
		$finish;
	end

	function automatic int clamp_rate(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int any_rate();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// one sample beat, after a random gap unless sending calm
	task automatic offer_sample(input int x, input int y, input int z, input bit ok);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid        <= 1'b1;
		samples_if.rate_x       <= x[RATE_W-1:0];
		samples_if.rate_y       <= y[RATE_W-1:0];
		samples_if.rate_z       <= z[RATE_W-1:0];
		samples_if.sample_valid <= ok;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
		if (sent % 50 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
	endtask

	// drain, then write the threshold while the block is idle
	task automatic load_threshold(input int unsigned v);
		samples_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[THR_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// a run of samples of one character; about one in eight is a failed read
	task automatic run_stretch(input stim_mode_t mode, input int count, input int thr);
		int bias  [AXES];
		int swing [AXES];
		int r     [AXES];
		int amp;
		int cap;
		bit flip;
		bit ok;
		flip = 1'b0;
		cap  = (thr * 2 + 8 > 4000) ? 4000 : thr * 2 + 8;
		amp  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(1, cap);
		for (int a = 0; a < AXES; a++) begin
			bias[a]  = any_rate();
			swing[a] = thr + $urandom_range(0, 2) - 1;
			if (swing[a] < 0)
				swing[a] = 0;
			if (swing[a] > 32767)
				swing[a] = 32767;
		end
		for (int i = 0; i < count; i++) begin
			ok = ($urandom_range(0, 7) != 0);
			for (int a = 0; a < AXES; a++) begin
				if (!ok)
					r[a] = any_rate();
				else
					case (mode)
						M_QUIET:  r[a] = clamp_rate(bias[a] + int'($urandom_range(0, 2 * amp)) - amp);
						M_WILD:   r[a] = any_rate();
						M_STEADY: r[a] = bias[a];
						M_SWING:  r[a] = flip ? swing[a] : -swing[a];
						default:  r[a] = $urandom_range(0, 1) ? 32767 : -32768;
					endcase
			end
			if (ok)
				flip = ~flip;
			offer_sample(r[0], r[1], r[2], ok);
		end
	endtask

	// result side: random stalls, two long hold-offs to back the block up
	initial begin
		int stall;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_calm ? 0 : $urandom_range(0, 11);
			if (beats == 300 || beats == 1100)
				stall = HOLD_CYCLES;
			if (stall != 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			results_if.ready <= 1'b1;
			@(posedge clk);
			while (!results_if.valid)
				@(posedge clk);
			@(negedge clk);
			beats++;
			if (beats % 64 == 0)
				recv_calm = ($urandom_range(0, 3) == 0);
		end
	end

	// stimulus and verdict
	initial begin
		int thr;
		int left;
		int n;
		samples_if.valid        = 1'b0;
		samples_if.rate_x       = '0;
		samples_if.rate_y       = '0;
		samples_if.rate_z       = '0;
		samples_if.sample_valid = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: failed read on an empty window, field extremes, bit patterns
		offer_sample(-32768, 32767, -1, 1'b0);
		offer_sample(0, 0, 0, 1'b1);
		offer_sample(32767, 32767, 32767, 1'b1);
		offer_sample(-32768, -32768, -32768, 1'b1);
		offer_sample(32767, -32768, 0, 1'b1);
		offer_sample(-1, 1, -2, 1'b1);
		offer_sample(16'h5555, -16'sh5556, 16'h00FF, 1'b1);
		offer_sample(16'h2AAA, 16'h5555, -256, 1'b0);
		offer_sample(-16'sh5556, 16'h5555, -256, 1'b1);
		offer_sample(0, 0, 0, 1'b0);

		// phases: fixed thresholds including the extremes first, then random settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       thr = 0;
				1:       thr = 1;
				2:       thr = 65535;
				3:       thr = 2;
				4:       thr = 64;
				5:       thr = 1000;
				6:       thr = 16;
				7:       thr = 32767;
				default: thr = $urandom_range(0, 1) ? $urandom_range(0, 600)
						: $urandom_range(0, 65535);
			endcase
			load_threshold(thr);
			left = PHASE_ITEMS;
			while (left > 0) begin
				n = $urandom_range(20, 90);
				if (n > left)
					n = left;
				run_stretch(stim_mode_t'($urandom_range(0, 4)), n, thr);
				left -= n;
			end
		end

		samples_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE * 2) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS gyro_window_stationary_detect");
		else
			$display("FAIL gyro_window_stationary_detect");
		$finish;
	end

endmodule
